@@ hdl/pulse_dir_encoder_counter_rpm_assert.svh @@
// assertion macros used by the checker file
`ifndef PULSE_DIR_ENCODER_COUNTER_RPM_ASSERT_SVH
`define PULSE_DIR_ENCODER_COUNTER_RPM_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PDEC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define PDEC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hdl/pdec_pkg.sv @@
// shared constants and types of the encoder counter
package pdec_pkg;

  localparam int NUM_CHANNELS_DEF = 4;

  // request kinds
  localparam logic [1:0] KIND_PIN   = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_SET   = 2'd2;

  // register indexes
  localparam logic [2:0] REG_DIR_INVERT = 3'd0;
  localparam logic [2:0] REG_RES0       = 3'd1;
  localparam logic [2:0] REG_RES3       = 3'd4;
  localparam logic [2:0] REG_MIN_PERIOD = 3'd5;

  // speed constants
  localparam logic [31:0] STILL_PERIOD_US   = 32'd1000000;
  localparam logic [31:0] USEC_PER_MINUTE   = 32'd60000000;
  localparam logic [31:0] MIN_COUNTS        = 32'd10;
  localparam logic [31:0] MIN_PERIOD_RESET  = 32'd10000000;

  // divider widths: numerator mag*60e6 < 2^57, denominator res*elapsed < 2^48
  localparam int RPM_W = 16;
  localparam int NUM_W = 57;
  localparam int DEN_W = 48;
  localparam int DVD_W = NUM_W + 2;
  localparam int DSR_W = DEN_W + 1;
  localparam int CNT_W = $clog2(DVD_W + 1);

  localparam logic [RPM_W-1:0] RPM_MAX = '1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_QCHK,
    S_MUL_NUM,
    S_MUL_DEN,
    S_DIV_START,
    S_DIV_WAIT,
    S_RESULT
  } state_t;

endpackage

@@ hdl/pdec_div.sv @@
// restoring divider, one quotient bit per cycle, saturating to 16 bits
module pdec_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [pdec_pkg::DVD_W-1:0]   dividend,
  input  logic [pdec_pkg::DSR_W-1:0]   divisor,
  output logic                         done,
  output logic [pdec_pkg::RPM_W-1:0]   quotient
);
  import pdec_pkg::*;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DVD_W-1:0] dvd;
  logic [DSR_W-1:0] dsr;
  logic [DSR_W-1:0] rem;
  logic [RPM_W-1:0] q;
  logic             sat;
  logic [DSR_W:0]   trial;
  logic [DSR_W:0]   diff;
  logic             ge;

  // shared compare and subtract
  assign trial = {rem, dvd[DVD_W-1]};
  assign diff  = trial - {1'b0, dsr};
  assign ge    = trial >= {1'b0, dsr};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
      q   <= '0;
      sat <= 1'b0;
    end else if (busy) begin
      rem <= ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
      dvd <= {dvd[DVD_W-2:0], 1'b0};
      q   <= {q[RPM_W-2:0], ge};
      sat <= sat | q[RPM_W-1];
    end
  end

  assign quotient = sat ? RPM_MAX : q;

endmodule

@@ hdl/pulse_dir_encoder_counter_rpm.sv @@
// top level: encoder counters, speed sequencer and result register
//
//  channel   signals                                   handshake
//  in        kind channel pulse_levels changed_pins    in_valid / in_ready
//            dir_levels new_position time_us
//  out       position speed_rpm                        out_valid / out_ready
//  cfg       cfg_index cfg_data                        cfg_we (no wait)
//
// pin and set requests go from the execute state to the result state; a query to a valid
// channel that computes nothing passes the check state between them. the next request is
// taken the cycle after the result register loads. a query that computes a new speed runs
// the 59 steps of the serial divider and its done cycle, after two passes through the
// shared 32x32 multiplier.
// one request is in work at a time; the next is accepted while a result waits.
// rst is synchronous and clears all counts, samples, speeds and configuration registers.
module pulse_dir_encoder_counter_rpm #(
  parameter int NUM_CHANNELS = pdec_pkg::NUM_CHANNELS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         kind,
  input  logic [1:0]         channel,
  input  logic [3:0]         pulse_levels,
  input  logic [3:0]         changed_pins,
  input  logic [3:0]         dir_levels,
  input  logic signed [31:0] new_position,
  input  logic [31:0]        time_us,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] position,
  output logic [15:0]        speed_rpm
);
  import pdec_pkg::*;

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  state_t state, state_next;

  // configuration
  logic [3:0]  dir_invert;
  logic [15:0] res [NUM_CHANNELS];
  logic [31:0] min_period;
  logic [2:0]  res_sel;

  // channel state
  logic [31:0]      count    [NUM_CHANNELS];
  logic [31:0]      scount   [NUM_CHANNELS];
  logic [31:0]      stime    [NUM_CHANNELS];
  logic [RPM_W-1:0] held     [NUM_CHANNELS];

  // latched request
  logic [1:0]  kind_r;
  logic [1:0]  ch_r;
  logic [3:0]  pulse_r;
  logic [3:0]  changed_r;
  logic [3:0]  dir_r;
  logic [31:0] newpos_r;
  logic [31:0] time_r;

  logic [CH_W-1:0] ci;
  logic            ch_ok;

  // query working registers
  logic [31:0] delta_r;
  logic [31:0] elapsed_r;
  logic [31:0] mag;
  logic [31:0] mag_r;
  logic        q_still;
  logic        q_move;
  logic        q_compute;

  // shared multiplier
  logic [31:0]      mul_a;
  logic [31:0]      mul_b;
  logic [63:0]      prod_r;
  logic [NUM_W-1:0] num_r;

  // divider link
  logic             div_start;
  logic             div_done;
  logic [DVD_W-1:0] div_dividend;
  logic [DSR_W-1:0] div_divisor;
  logic [RPM_W-1:0] div_q;

  logic load_out;

  assign ci    = ch_r[CH_W-1:0];
  assign ch_ok = {1'b0, ch_r} < 3'(NUM_CHANNELS);

  // query decision
  assign mag       = delta_r[31] ? (32'd0 - delta_r) : delta_r;
  assign q_still   = (mag == 32'd0);
  assign q_move    = !q_still && ((mag >= MIN_COUNTS) || (elapsed_r > min_period))
                     && (res[ci] != 16'd0);
  assign q_compute = q_move && (elapsed_r != 32'd0);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      if (in_valid) state_next = S_EXEC;
      S_EXEC:      state_next = (ch_ok && kind_r == KIND_QUERY) ? S_QCHK : S_RESULT;
      S_QCHK:      state_next = q_compute ? S_MUL_NUM : S_RESULT;
      S_MUL_NUM:   state_next = S_MUL_DEN;
      S_MUL_DEN:   state_next = S_DIV_START;
      S_DIV_START: state_next = S_DIV_WAIT;
      S_DIV_WAIT:  if (div_done) state_next = S_RESULT;
      S_RESULT:    if (!out_valid || out_ready) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    mul_a     = mag_r;
    mul_b     = USEC_PER_MINUTE;
    unique case (state)
      S_IDLE:      in_ready = 1'b1;
      S_MUL_DEN: begin
        mul_a = {16'd0, res[ci]};
        mul_b = elapsed_r;
      end
      S_DIV_START: div_start = 1'b1;
      S_RESULT:    load_out = !out_valid || out_ready;
      default:     ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration writes
  assign res_sel = cfg_index - REG_RES0;

  always_ff @(posedge clk) begin
    if (rst) begin
      dir_invert <= '0;
      min_period <= MIN_PERIOD_RESET;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        res[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index) inside
        REG_DIR_INVERT: dir_invert <= cfg_data[3:0];
        [REG_RES0:REG_RES3]: begin
          if (res_sel < 3'(NUM_CHANNELS)) res[res_sel[CH_W-1:0]] <= cfg_data[15:0];
        end
        REG_MIN_PERIOD: min_period <= cfg_data;
        default: ;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_r    <= kind;
      ch_r      <= channel;
      pulse_r   <= pulse_levels;
      changed_r <= changed_pins;
      dir_r     <= dir_levels;
      newpos_r  <= new_position;
      time_r    <= time_us;
    end
  end

  // query operands and multiplier pipeline
  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      delta_r   <= count[ci] - scount[ci];
      elapsed_r <= time_r - stime[ci];
    end
    if (state == S_QCHK) mag_r <= mag;
    if (state == S_MUL_DEN) num_r <= prod_r[NUM_W-1:0];
    prod_r <= mul_a * mul_b;
  end

  // divider operands: (2*num + den) / (2*den)
  assign div_dividend = DVD_W'({num_r, 1'b0}) + DVD_W'(prod_r[DEN_W-1:0]);
  assign div_divisor  = {prod_r[DEN_W-1:0], 1'b0};

  pdec_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // channel state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        count[i]  <= '0;
        scount[i] <= '0;
        stime[i]  <= '0;
        held[i]   <= '0;
      end
    end else begin
      case (state)
        S_EXEC: begin
          if (ch_ok && kind_r == KIND_PIN) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
              if (changed_r[i] && pulse_r[i]) begin
                count[i] <= (dir_r[i] ^ dir_invert[i]) ? count[i] + 32'd1
                                                       : count[i] - 32'd1;
              end
            end
          end else if (ch_ok && kind_r == KIND_SET) begin
            count[ci] <= newpos_r;
          end
        end
        S_QCHK: begin
          if (q_still) begin
            if (elapsed_r > STILL_PERIOD_US) begin
              stime[ci] <= time_r;
              held[ci]  <= held[ci] >> 1;
            end
          end else if (q_move && !q_compute) begin
            // no time elapsed: saturate
            held[ci]   <= RPM_MAX;
            scount[ci] <= count[ci];
            stime[ci]  <= time_r;
          end
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            held[ci]   <= div_q;
            scount[ci] <= count[ci];
            stime[ci]  <= time_r;
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      position  <= ch_ok ? count[ci] : 32'd0;
      speed_rpm <= ch_ok ? held[ci] : 16'd0;
    end
  end

endmodule

@@ hdl/pdec_checker.sv @@
// port-level checker for the encoder counter and its bind
module pdec_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] position,
  input logic [15:0]        speed_rpm
);
`include "pulse_dir_encoder_counter_rpm_assert.svh"

  // no result right after reset
  `PDEC_ASSERT_NOW(a_reset_empty, clk, rst, $past(rst), !out_valid)

  // a stalled result holds its value
  `PDEC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(position) && $stable(speed_rpm))

  // one request at a time: busy right after accept
  `PDEC_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)

  // a fresh result frees the input side in the same cycle
  `PDEC_ASSERT_NOW(a_ready_with_result, clk, rst, $rose(out_valid), in_ready)

endmodule

bind pulse_dir_encoder_counter_rpm pdec_checker u_pdec_checker (.*);
